[hw/rtl/assert_macros.svh]
// Assertion macros for the register ALU checker.
// Used by rva_checker.sv; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define RVA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("rva assertion failed");

// Trigger followed by a consequence a fixed number of cycles later.
`define RVA_ASSERT_LAT(lbl, clk, rst_n, trig, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) trig |-> ##n cons) \
		else $error("rva latency assertion failed");

`endif

[hw/rtl/rva_pkg.sv]
// Shared types and constants for the RV32IM register ALU.
// No dependencies.
package rva_pkg;

	localparam int XLEN       = 32;
	localparam int DIV_STAGES = 32;
	// input register, operand stage, divider stages, output register
	localparam int LATENCY    = DIV_STAGES + 3;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_SUB   = 5'd1,
		OP_AND   = 5'd2,
		OP_OR    = 5'd3,
		OP_XOR   = 5'd4,
		OP_SLL   = 5'd5,
		OP_SRL   = 5'd6,
		OP_SRA   = 5'd7,
		OP_SLT   = 5'd8,
		OP_SLTU  = 5'd9,
		OP_MUL   = 5'd10,
		OP_MULH  = 5'd11,
		OP_MULHU = 5'd12,
		OP_DIV   = 5'd13,
		OP_DIVU  = 5'd14,
		OP_REM   = 5'd15,
		OP_REMU  = 5'd16
	} op_e;

	typedef struct packed {
		logic [4:0]      mode;
		logic [XLEN-1:0] operand_a;
		logic [XLEN-1:0] operand_b;
	} in_t;

	typedef struct packed {
		logic [XLEN-1:0] result_value;
		logic            invalid_op;
	} out_t;

	// travels beside the divider
	typedef struct packed {
		logic            valid;
		logic            is_div;
		logic            is_rem;
		logic            neg;
		logic            bad;
		logic [XLEN-1:0] res;
	} tag_t;

endpackage

[hw/rtl/rva_alu.sv]
// Combinational integer operations: add/sub, logic, shifts, compares.
// Depends on rva_pkg.
module rva_alu (
	input  logic [4:0]               mode,
	input  logic [rva_pkg::XLEN-1:0] a,
	input  logic [rva_pkg::XLEN-1:0] b,
	output logic [rva_pkg::XLEN-1:0] res
);

	logic [4:0] sh;

	assign sh = b[4:0];

	always_comb begin
		case (mode)
			rva_pkg::OP_ADD:  res = a + b;
			rva_pkg::OP_SUB:  res = a - b;
			rva_pkg::OP_AND:  res = a & b;
			rva_pkg::OP_OR:   res = a | b;
			rva_pkg::OP_XOR:  res = a ^ b;
			rva_pkg::OP_SLL:  res = a << sh;
			rva_pkg::OP_SRL:  res = a >> sh;
			rva_pkg::OP_SRA:  res = $unsigned($signed(a) >>> sh);
			rva_pkg::OP_SLT:  res = {31'd0, $signed(a) < $signed(b)};
			rva_pkg::OP_SLTU: res = {31'd0, a < b};
			default:          res = '0;
		endcase
	end

endmodule

[hw/rtl/rva_divider.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on rva_pkg. Divisor zero yields all-ones quotient, remainder = dividend.
module rva_divider (
	input  logic                     clk,
	input  logic [rva_pkg::XLEN-1:0] dvd,
	input  logic [rva_pkg::XLEN-1:0] dvs,
	output logic [rva_pkg::XLEN-1:0] quo,
	output logic [rva_pkg::XLEN-1:0] rem
);

	localparam int N = rva_pkg::DIV_STAGES;
	localparam int W = rva_pkg::XLEN;

	logic [W-1:0] rem_q [N];
	logic [W-1:0] quo_q [N];
	logic [W-1:0] dvs_q [N];
	logic [W-1:0] rem_nxt [N];
	logic [W-1:0] quo_nxt [N];
	logic [W-1:0] dvs_nxt [N];

	always_comb begin
		logic [W-1:0] r_in;
		logic [W-1:0] q_in;
		logic [W:0]   trial;
		logic [W:0]   diff;
		logic         ge;
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				r_in       = '0;
				q_in       = dvd;
				dvs_nxt[k] = dvs;
			end else begin
				r_in       = rem_q[k-1];
				q_in       = quo_q[k-1];
				dvs_nxt[k] = dvs_q[k-1];
			end
			trial      = {r_in, q_in[W-1]};
			ge         = trial >= {1'b0, dvs_nxt[k]};
			diff       = trial - {1'b0, dvs_nxt[k]};
			rem_nxt[k] = ge ? diff[W-1:0] : trial[W-1:0];
			quo_nxt[k] = {q_in[W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			rem_q[k] <= rem_nxt[k];
			quo_q[k] <= quo_nxt[k];
			dvs_q[k] <= dvs_nxt[k];
		end
	end

	assign quo = quo_q[N-1];
	assign rem = rem_q[N-1];

endmodule

[hw/rtl/rv32im_register_alu.sv]
// RV32IM register-register ALU, fully pipelined.
// Channels: req is transferred at a rising edge with start high and busy low.
// busy is always low: a new operation may be issued every cycle.
// rsp is shown for one cycle with done high; the receiver takes it then and
// cannot stall the block, so no hold-off exists.
// Pipeline: every operation passes the input register, operand stage (alu ops,
// 33x33 multiplier, divider operand magnitudes), 32 divider stages at one
// quotient bit each, and the output register. All operations pass the same
// registers, so results leave in issue order.
// Throughput: one operation per cycle.
// Reset (arst_n low, asynchronous) clears all valid bits; operations in
// flight are dropped and no done follows them.
// Depends on rva_pkg, rva_alu, rva_divider.
module rv32im_register_alu (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rva_pkg::in_t  req,
	output logic          done,
	output rva_pkg::out_t rsp
);

	localparam int W = rva_pkg::XLEN;
	localparam int N = rva_pkg::DIV_STAGES;

	// stage 1: input register
	logic         valid_s1;
	rva_pkg::in_t req_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	// stage 1 decode
	logic [W-1:0] alu_res;
	logic         is_div;
	logic         is_rem;
	logic         is_sgn;
	logic         is_mul;
	logic         mul_hi;
	logic         a_sgn;
	logic         b_sgn;
	logic         neg;
	logic         bad;
	logic [W:0]   ma;
	logic [W:0]   mb;

	rva_alu u_alu (
		.mode (req_s1.mode),
		.a    (req_s1.operand_a),
		.b    (req_s1.operand_b),
		.res  (alu_res)
	);

	always_comb begin
		is_div = req_s1.mode inside {rva_pkg::OP_DIV, rva_pkg::OP_DIVU,
			rva_pkg::OP_REM, rva_pkg::OP_REMU};
		is_rem = req_s1.mode inside {rva_pkg::OP_REM, rva_pkg::OP_REMU};
		is_sgn = req_s1.mode inside {rva_pkg::OP_DIV, rva_pkg::OP_REM};
		is_mul = req_s1.mode inside {rva_pkg::OP_MUL, rva_pkg::OP_MULH,
			rva_pkg::OP_MULHU};
		mul_hi = req_s1.mode inside {rva_pkg::OP_MULH, rva_pkg::OP_MULHU};
		bad    = req_s1.mode > rva_pkg::OP_REMU;
		a_sgn  = req_s1.operand_a[W-1];
		b_sgn  = req_s1.operand_b[W-1];
		// div by zero keeps the all-ones quotient unsigned
		neg    = is_sgn && (is_rem ? a_sgn
			: ((a_sgn ^ b_sgn) && (req_s1.operand_b != '0)));
		// mulh sign-extends, mul and mulhu zero-extend
		ma = {(req_s1.mode == rva_pkg::OP_MULH) && a_sgn, req_s1.operand_a};
		mb = {(req_s1.mode == rva_pkg::OP_MULH) && b_sgn, req_s1.operand_b};
	end

	// stage 2: operands, product
	rva_pkg::tag_t  tag_s2;
	logic           is_mul_s2;
	logic           mul_hi_s2;
	logic [2*W+1:0] prod_s2;
	logic [W-1:0]   dvd_s2;
	logic [W-1:0]   dvs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2.valid  <= valid_s1;
			tag_s2.is_div <= is_div;
			tag_s2.is_rem <= is_rem;
			tag_s2.neg    <= neg;
			tag_s2.bad    <= bad;
			tag_s2.res    <= alu_res;
		end
	end

	// signed operands widen to the full 66-bit product
	always_ff @(posedge clk) begin
		is_mul_s2     <= is_mul;
		mul_hi_s2     <= mul_hi;
		prod_s2       <= $signed(ma) * $signed(mb);
		dvd_s2        <= (is_sgn && a_sgn) ? W'(-req_s1.operand_a) : req_s1.operand_a;
		dvs_s2        <= (is_sgn && b_sgn) ? W'(-req_s1.operand_b) : req_s1.operand_b;
	end

	// divider and the tag line beside it
	logic [W-1:0]  quo;
	logic [W-1:0]  rem;
	rva_pkg::tag_t tag_in;
	rva_pkg::tag_t tag_q [N];

	rva_divider u_div (
		.clk (clk),
		.dvd (dvd_s2),
		.dvs (dvs_s2),
		.quo (quo),
		.rem (rem)
	);

	always_comb begin
		tag_in = tag_s2;
		if (is_mul_s2) begin
			tag_in.res = mul_hi_s2 ? prod_s2[2*W-1:W] : prod_s2[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) begin
				tag_q[k] <= '0;
			end
		end else begin
			tag_q[0] <= tag_in;
			for (int k = 1; k < N; k++) begin
				tag_q[k] <= tag_q[k-1];
			end
		end
	end

	// output register
	rva_pkg::tag_t tag_last;
	logic [W-1:0]  div_val;
	logic [W-1:0]  fin;
	logic          done_q;
	rva_pkg::out_t rsp_q;

	always_comb begin
		tag_last = tag_q[N-1];
		div_val  = tag_last.is_rem ? rem : quo;
		if (tag_last.neg) begin
			div_val = W'(-div_val);
		end
		fin = tag_last.is_div ? div_val : tag_last.res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tag_last.valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q.result_value <= fin;
		rsp_q.invalid_op   <= tag_last.bad;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[hw/rtl/rva_checker.sv]
// Port-level checker for rv32im_register_alu, bound to the top level.
// Depends on rva_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rva_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input rva_pkg::out_t rsp
);

	`RVA_ASSERT(a_never_busy, clk, arst_n, !busy)
	`RVA_ASSERT_LAT(a_fixed_latency, clk, arst_n, start, 35, done)
	`RVA_ASSERT(a_invalid_zero, clk, arst_n, (done && rsp.invalid_op) |-> (rsp.result_value == '0))

endmodule

bind rv32im_register_alu rva_checker u_rva_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

[tb/sv/rv32im_register_alu_tb.sv]
// Testbench for rv32im_register_alu: directed table plus random operations,
// each result checked against its table row's value or an in-bench RV32IM model.
// Depends on rva_pkg and the rv32im_register_alu RTL.
`timescale 1ns / 100ps

module rv32im_register_alu_tb;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int N_RANDOM        = 400;
	localparam logic [4:0] OP_BAD  = 5'd17;
	localparam logic [4:0] OP_TOP  = 5'd31;

	typedef struct packed {
		rva_pkg::in_t  op;
		logic          has_exp;
		rva_pkg::out_t exp;
	} row_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	rva_pkg::in_t  req;
	logic          done;
	rva_pkg::out_t rsp;

	rva_pkg::out_t pending_results[$];
	int            n_errors;
	int            idle_cycles;
	bit            timed_out;

	rv32im_register_alu dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic rva_pkg::out_t alu_compute(rva_pkg::in_t op);
		rva_pkg::out_t      r;
		logic [31:0]        a, b, ma, mb, q, rm;
		logic [4:0]         sh;
		logic signed [63:0] sp;
		logic [63:0]        up;
		a  = op.operand_a;
		b  = op.operand_b;
		sh = b[4:0];
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q  = (mb != 0) ? ma / mb : '0;
		rm = (mb != 0) ? ma % mb : '0;
		r.invalid_op   = 1'b0;
		r.result_value = '0;
		case (op.mode)
			rva_pkg::OP_ADD:   r.result_value = a + b;
			rva_pkg::OP_SUB:   r.result_value = a - b;
			rva_pkg::OP_AND:   r.result_value = a & b;
			rva_pkg::OP_OR:    r.result_value = a | b;
			rva_pkg::OP_XOR:   r.result_value = a ^ b;
			rva_pkg::OP_SLL:   r.result_value = a << sh;
			rva_pkg::OP_SRL:   r.result_value = a >> sh;
			rva_pkg::OP_SRA:   r.result_value = $unsigned($signed(a) >>> sh);
			rva_pkg::OP_SLT:   r.result_value = {31'd0, $signed(a) < $signed(b)};
			rva_pkg::OP_SLTU:  r.result_value = {31'd0, a < b};
			rva_pkg::OP_MUL:   r.result_value = a * b;
			rva_pkg::OP_MULH: begin
				sp = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
				r.result_value = sp[63:32];
			end
			rva_pkg::OP_MULHU: begin
				up = {32'd0, a} * {32'd0, b};
				r.result_value = up[63:32];
			end
			rva_pkg::OP_DIV:
				r.result_value = (b == 0) ? '1 : ((a[31] ^ b[31]) ? -q : q);
			rva_pkg::OP_DIVU:  r.result_value = (b == 0) ? '1 : a / b;
			rva_pkg::OP_REM:   r.result_value = (b == 0) ? a : (a[31] ? -rm : rm);
			rva_pkg::OP_REMU:  r.result_value = (b == 0) ? a : a % b;
			default:           r.invalid_op = 1'b1;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	// result checking
	always @(posedge clk) begin
		rva_pkg::out_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h/%b", $time, rsp.result_value,
					rsp.invalid_op);
				n_errors++;
			end else begin
				e = pending_results.pop_front();
				if (rsp.result_value !== e.result_value)
					$display("%0t: result_value expected %h actual %h", $time,
						e.result_value, rsp.result_value);
				if (rsp.invalid_op !== e.invalid_op)
					$display("%0t: invalid_op expected %b actual %b", $time,
						e.invalid_op, rsp.invalid_op);
				if (rsp.result_value !== e.result_value || rsp.invalid_op !== e.invalid_op)
					n_errors++;
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES && !timed_out) begin
			timed_out = 1'b1;
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic issue(rva_pkg::in_t op, logic has_exp, rva_pkg::out_t exp);
		rva_pkg::out_t p;
		p = alu_compute(op);
		if (has_exp && p !== exp) begin
			$display("%0t: table row mode %0d expected %h/%b model %h/%b", $time,
				op.mode, exp.result_value, exp.invalid_op, p.result_value, p.invalid_op);
			n_errors++;
		end
		start <= 1'b1;
		req   <= op;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(has_exp ? exp : p);
	endtask

	task automatic gap(int n);
		if (n > 0) begin
			start <= 1'b0;
			req   <= '{mode: 5'($urandom), operand_a: $urandom, operand_b: $urandom};
			repeat (n) @(posedge clk);
		end
	endtask

	row_t directed[$];

	function automatic row_t mk(logic [4:0] m, logic [31:0] a, logic [31:0] b,
			int he, logic [31:0] ev, int ei);
		row_t r;
		r.op.mode = m; r.op.operand_a = a; r.op.operand_b = b;
		r.has_exp = (he != 0); r.exp.result_value = ev; r.exp.invalid_op = (ei != 0);
		return r;
	endfunction

	initial begin
		int            burst;
		rva_pkg::in_t  op;
		rva_pkg::out_t none;
		none      = '0;
		n_errors  = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;

		directed.push_back(mk(rva_pkg::OP_ADD,   32'hFFFF_FFFF, 32'h1, 1, 32'h0, 0));
		directed.push_back(mk(rva_pkg::OP_SUB,   32'h0, 32'h1, 1, 32'hFFFF_FFFF, 0));
		directed.push_back(mk(rva_pkg::OP_AND,   32'hFFFF_FFFF, 32'hA5A5_5A5A,
			1, 32'hA5A5_5A5A, 0));
		directed.push_back(mk(rva_pkg::OP_OR,    32'h0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0));
		directed.push_back(mk(rva_pkg::OP_XOR,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, 0));
		// shift amount uses only the low five bits of operand_b
		directed.push_back(mk(rva_pkg::OP_SLL,   32'h1, 32'hFFFF_FFFF, 1, 32'h8000_0000, 0));
		directed.push_back(mk(rva_pkg::OP_SRL,   32'h8000_0000, 32'h20, 1, 32'h8000_0000, 0));
		directed.push_back(mk(rva_pkg::OP_SRA,   32'h8000_0000, 32'h1F, 1, 32'hFFFF_FFFF, 0));
		directed.push_back(mk(rva_pkg::OP_SLT,   32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h1, 0));
		directed.push_back(mk(rva_pkg::OP_SLTU,  32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h0, 0));
		directed.push_back(mk(rva_pkg::OP_MUL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h1, 0));
		directed.push_back(mk(rva_pkg::OP_MULH,  32'h8000_0000, 32'h8000_0000,
			1, 32'h4000_0000, 0));
		directed.push_back(mk(rva_pkg::OP_MULHU, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1, 32'hFFFF_FFFE, 0));
		directed.push_back(mk(rva_pkg::OP_MULH,  32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
		// divide by zero
		directed.push_back(mk(rva_pkg::OP_DIV,   32'h1234_5678, 32'h0, 1, 32'hFFFF_FFFF, 0));
		directed.push_back(mk(rva_pkg::OP_DIVU,  32'h0, 32'h0, 1, 32'hFFFF_FFFF, 0));
		directed.push_back(mk(rva_pkg::OP_REM,   32'h8765_4321, 32'h0, 1, 32'h8765_4321, 0));
		directed.push_back(mk(rva_pkg::OP_REMU,  32'hFFFF_FFFF, 32'h0, 1, 32'hFFFF_FFFF, 0));
		// signed overflow, then signed and unsigned division checked by the model only
		directed.push_back(mk(rva_pkg::OP_DIV,   32'h8000_0000, 32'hFFFF_FFFF,
			1, 32'h8000_0000, 0));
		directed.push_back(mk(rva_pkg::OP_REM,   32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h0, 0));
		directed.push_back(mk(rva_pkg::OP_DIV,   32'hFFFF_FFF9, 32'h2, 0, 0, 0));
		directed.push_back(mk(rva_pkg::OP_REM,   32'hFFFF_FFF9, 32'h2, 0, 0, 0));
		directed.push_back(mk(rva_pkg::OP_DIVU,  32'hFFFF_FFFF, 32'h7, 0, 0, 0));
		// unknown codes
		directed.push_back(mk(OP_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, 1));
		directed.push_back(mk(OP_TOP, 32'h1, 32'h1, 1, 32'h0, 1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			issue(directed[i].op, directed[i].has_exp, directed[i].exp);
			if ($urandom_range(0, 3) == 0) gap($urandom_range(1, 3));
		end

		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 30);
			for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
				// mostly legal codes, occasionally any 5-bit code
				op.mode = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
					: 5'($urandom_range(0, 16));
				op.operand_a = pick_operand();
				op.operand_b = pick_operand();
				issue(op, 1'b0, none);
			end
			if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 8));
		end
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (rva_pkg::LATENCY + 5) @(posedge clk);

		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[rv32im_register_alu.f]
+incdir+hw/rtl
hw/rtl/rva_pkg.sv
hw/rtl/rva_alu.sv
hw/rtl/rva_divider.sv
hw/rtl/rv32im_register_alu.sv
hw/rtl/rva_checker.sv
tb/sv/rv32im_register_alu_tb.sv
